[design/ir_serial_byte_frame_decoder_unit_macros.svh]
// assertion macros for the ir serial byte frame decoder
`ifndef IR_SERIAL_BYTE_FRAME_DECODER_UNIT_MACROS_SVH
`define IR_SERIAL_BYTE_FRAME_DECODER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define IRSBFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IRSBFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/irsbfd_pkg.sv]
// shared types and codes of the ir serial byte frame decoder
package irsbfd_pkg;

    localparam int unsigned ADDR_W = 6;
    localparam int unsigned DATA_W = 64;

    localparam logic [7:0] HDR_IDENT = 8'hff;
    localparam logic [7:0] HDR_FLOW  = 8'haa;

    typedef enum logic [2:0] {
        REG_IDENT_START = 3'd0,
        REG_FLOW_START  = 3'd1,
        REG_READ_FLOW   = 3'd2,
        REG_MENU        = 3'd3,
        REG_OTHER_IDENT = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        EV_BYTE       = 4'd0,
        EV_FLOW       = 4'd1,
        EV_READ_FLOW  = 4'd2,
        EV_FLOW_BACK  = 4'd3,
        EV_IDENT      = 4'd4,
        EV_CLOSE      = 4'd5,
        EV_OPEN       = 4'd6,
        EV_ADD        = 4'd7,
        EV_SUB        = 4'd8,
        EV_CONFIRM    = 4'd9,
        EV_DOWN       = 4'd10,
        EV_BACK       = 4'd11,
        EV_READ_IDENT = 4'd12,
        EV_ABORT      = 4'd13,
        EV_START_ERR  = 4'd14
    } event_t;

    typedef struct packed {
        logic [7:0]  ident_start_code;
        logic [7:0]  flow_start_code;
        logic [7:0]  read_flow_code;
        logic [39:0] menu_codes;
        logic [23:0] other_ident_codes;
    } cfg_t;

    typedef struct packed {
        event_t      evt;
        logic [7:0]  byte_value;
        logic [15:0] value_first;
        logic [15:0] value_second;
    } res_t;

    // either nibble above nine
    function automatic logic not_bcd(input logic [7:0] b);
        return (b[3:0] > 4'd9) || (b[7:4] > 4'd9);
    endfunction

endpackage

[design/irsbfd_frame_parser.sv]
// frame parser: header tracking, command matching and bcd payload gathering
module irsbfd_frame_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  irsbfd_pkg::cfg_t     cfg,
    input  logic                 byte_strobe,
    input  logic [7:0]           rx_byte,
    output irsbfd_pkg::event_t   evt,
    output logic [15:0]          value_first,
    output logic [15:0]          value_second
);

    logic        header_seen_reg, header_seen_next;
    logic        flow_mode_reg, flow_mode_next;
    logic        flow_on_reg, flow_on_next;
    logic [1:0]  flow_idx_reg, flow_idx_next;
    logic [15:0] flow_first_reg, flow_first_next;
    logic [7:0]  flow_sec_hi_reg, flow_sec_hi_next;
    logic        ident_on_reg, ident_on_next;
    logic [1:0]  ident_idx_reg, ident_idx_next;
    logic [7:0]  ident_first_reg, ident_first_next;
    logic [7:0]  ident_sec_hi_reg, ident_sec_hi_next;

    always_comb
    begin
        header_seen_next  = header_seen_reg;
        flow_mode_next    = flow_mode_reg;
        flow_on_next      = flow_on_reg;
        flow_idx_next     = flow_idx_reg;
        flow_first_next   = flow_first_reg;
        flow_sec_hi_next  = flow_sec_hi_reg;
        ident_on_next     = ident_on_reg;
        ident_idx_next    = ident_idx_reg;
        ident_first_next  = ident_first_reg;
        ident_sec_hi_next = ident_sec_hi_reg;
        evt          = irsbfd_pkg::EV_BYTE;
        value_first  = 16'd0;
        value_second = 16'd0;

        if (!header_seen_reg)
        begin
            if (rx_byte == irsbfd_pkg::HDR_IDENT)
            begin
                flow_mode_next   = 1'b0;
                header_seen_next = 1'b1;
            end
            else if (rx_byte == irsbfd_pkg::HDR_FLOW)
            begin
                flow_mode_next   = 1'b1;
                header_seen_next = 1'b1;
            end
        end
        else if (flow_mode_reg)
        begin
            header_seen_next = 1'b0;
            if (!flow_on_reg)
            begin
                flow_idx_next = 2'd0;
                if (rx_byte == cfg.flow_start_code)
                    flow_on_next = 1'b1;
                else if (rx_byte == cfg.read_flow_code)
                    evt = irsbfd_pkg::EV_READ_FLOW;
                else if (rx_byte == cfg.menu_codes[39:32])
                    evt = irsbfd_pkg::EV_FLOW_BACK;
            end
            else if (irsbfd_pkg::not_bcd(rx_byte))
            begin
                flow_on_next  = 1'b0;
                flow_idx_next = 2'd0;
                evt           = irsbfd_pkg::EV_ABORT;
            end
            else
            begin
                case (flow_idx_reg)
                    2'd0:
                    begin
                        flow_first_next = {rx_byte, 8'd0};
                        flow_idx_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        flow_first_next = {flow_first_reg[15:8], rx_byte};
                        flow_idx_next   = 2'd2;
                    end
                    2'd2:
                    begin
                        flow_sec_hi_next = rx_byte;
                        flow_idx_next    = 2'd3;
                    end
                    default:
                    begin
                        flow_on_next  = 1'b0;
                        flow_idx_next = 2'd0;
                        evt           = irsbfd_pkg::EV_FLOW;
                        value_first   = flow_first_reg;
                        value_second  = {flow_sec_hi_reg, rx_byte};
                    end
                endcase
            end
        end
        else
        begin
            header_seen_next = 1'b0;
            if (!ident_on_reg)
            begin
                ident_idx_next = 2'd0;
                if (rx_byte == cfg.ident_start_code)
                    ident_on_next = 1'b1;
                else if (rx_byte == cfg.other_ident_codes[7:0])
                    evt = irsbfd_pkg::EV_CLOSE;
                else if (rx_byte == cfg.other_ident_codes[15:8])
                    evt = irsbfd_pkg::EV_OPEN;
                else if (rx_byte == cfg.menu_codes[7:0])
                    evt = irsbfd_pkg::EV_ADD;
                else if (rx_byte == cfg.menu_codes[15:8])
                    evt = irsbfd_pkg::EV_SUB;
                else if (rx_byte == cfg.menu_codes[23:16])
                    evt = irsbfd_pkg::EV_CONFIRM;
                else if (rx_byte == cfg.menu_codes[31:24])
                    evt = irsbfd_pkg::EV_DOWN;
                else if (rx_byte == cfg.menu_codes[39:32])
                    evt = irsbfd_pkg::EV_BACK;
                else if (rx_byte == cfg.other_ident_codes[23:16])
                    evt = irsbfd_pkg::EV_READ_IDENT;
            end
            else if (irsbfd_pkg::not_bcd(rx_byte))
            begin
                ident_on_next  = 1'b0;
                ident_idx_next = 2'd0;
                evt            = irsbfd_pkg::EV_ABORT;
            end
            else
            begin
                case (ident_idx_reg)
                    2'd0:
                    begin
                        ident_first_next = rx_byte;
                        ident_idx_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        ident_sec_hi_next = rx_byte;
                        ident_idx_next    = 2'd2;
                    end
                    // index three is unreachable and behaves as index two
                    default:
                    begin
                        ident_on_next  = 1'b0;
                        ident_idx_next = 2'd0;
                        evt            = irsbfd_pkg::EV_IDENT;
                        value_first    = {8'd0, ident_first_reg};
                        value_second   = {ident_sec_hi_reg, rx_byte};
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_seen_reg <= 1'b0;
            flow_mode_reg   <= 1'b0;
            flow_on_reg     <= 1'b0;
            flow_idx_reg    <= 2'd0;
            ident_on_reg    <= 1'b0;
            ident_idx_reg   <= 2'd0;
        end
        else if (byte_strobe)
        begin
            header_seen_reg <= header_seen_next;
            flow_mode_reg   <= flow_mode_next;
            flow_on_reg     <= flow_on_next;
            flow_idx_reg    <= flow_idx_next;
            ident_on_reg    <= ident_on_next;
            ident_idx_reg   <= ident_idx_next;
        end
    end

    // payload words are only read after they have been written
    always_ff @(posedge clk)
    begin
        if (byte_strobe)
        begin
            flow_first_reg   <= flow_first_next;
            flow_sec_hi_reg  <= flow_sec_hi_next;
            ident_first_reg  <= ident_first_next;
            ident_sec_hi_reg <= ident_sec_hi_next;
        end
    end

endmodule

[design/ir_serial_byte_frame_decoder_unit.sv]
// top level of the ir serial byte frame decoder: receiver, config port and result buffer
//
// input channel (item_valid / item_stall, kind, line_level): one transaction per
// line event. kind 0 is an edge check after a falling edge, kind 1 a sampling tick.
// an edge check with the line low starts a byte; three ticks per bit are voted,
// followed by one idle tick; nine bits (start bit then data, lsb first) make a byte.
// result channel (result_valid / result_stall, event_res, byte_value, value_first,
// value_second): at most one transaction per input transaction, on the tick that
// completes a byte or detects a high start bit.
// throughput: one input transaction per clock while item_stall is low, as the receiver and
// parser update is combinational between the state registers and the result register.
// a result is registered in the output register, or in the skid entry on a stall.
// when the receiver stalls, a one-entry skid register holds a further result;
// item_stall is raised only while that skid entry is full.
// configuration: apb-style, 64-bit data, register i at byte address 8*i, to be written by
// the user while the block is idle (not enforced by the block); pready is tied high.
// reset (rst_n, asynchronous, active low) clears the receiver, the parser control state,
// the valid flags of the result buffer and all configuration registers to zero.
`include "ir_serial_byte_frame_decoder_unit_macros.svh"

module ir_serial_byte_frame_decoder_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [irsbfd_pkg::ADDR_W-1:0]     paddr,
    input  logic [irsbfd_pkg::DATA_W-1:0]     pwdata,
    output logic [irsbfd_pkg::DATA_W-1:0]     prdata,
    output logic                              pready,
    // input channel
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              kind,
    input  logic                              line_level,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [3:0]                        event_res,
    output logic [7:0]                        byte_value,
    output logic [15:0]                       value_first,
    output logic [15:0]                       value_second
);

    // configuration registers
    irsbfd_pkg::cfg_t      cfg_reg;
    irsbfd_pkg::reg_idx_t  reg_sel;
    logic                  cfg_write;

    // receiver state
    logic       receiving_reg, receiving_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] high_reg, high_next;
    logic [3:0] bit_idx_reg, bit_idx_next;
    logic [7:0] shift_reg, shift_next;

    logic       item_accept;
    logic       byte_done;
    logic       start_err;
    logic       res_valid;
    logic [1:0] high_inc;

    irsbfd_pkg::event_t  parse_evt;
    logic [15:0]         parse_v1;
    logic [15:0]         parse_v2;
    irsbfd_pkg::res_t    res_new;

    // result buffer: output register plus one skid entry
    logic              out_valid_reg;
    irsbfd_pkg::res_t  out_reg;
    logic              skid_valid_reg;
    irsbfd_pkg::res_t  skid_reg;
    logic              out_free;
    logic              res_push;

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign reg_sel   = irsbfd_pkg::reg_idx_t'(paddr[5:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                irsbfd_pkg::REG_IDENT_START: cfg_reg.ident_start_code  <= pwdata[7:0];
                irsbfd_pkg::REG_FLOW_START:  cfg_reg.flow_start_code   <= pwdata[7:0];
                irsbfd_pkg::REG_READ_FLOW:   cfg_reg.read_flow_code    <= pwdata[7:0];
                irsbfd_pkg::REG_MENU:        cfg_reg.menu_codes        <= pwdata[39:0];
                irsbfd_pkg::REG_OTHER_IDENT: cfg_reg.other_ident_codes <= pwdata[23:0];
                default: ;  // addresses past the register list are ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            irsbfd_pkg::REG_IDENT_START: prdata = {56'd0, cfg_reg.ident_start_code};
            irsbfd_pkg::REG_FLOW_START:  prdata = {56'd0, cfg_reg.flow_start_code};
            irsbfd_pkg::REG_READ_FLOW:   prdata = {56'd0, cfg_reg.read_flow_code};
            irsbfd_pkg::REG_MENU:        prdata = {24'd0, cfg_reg.menu_codes};
            irsbfd_pkg::REG_OTHER_IDENT: prdata = {40'd0, cfg_reg.other_ident_codes};
            default:                     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- receiver
    assign item_stall  = skid_valid_reg;
    assign item_accept = item_valid && !item_stall;
    assign high_inc    = high_reg + {1'b0, line_level};

    always_comb
    begin
        receiving_next = receiving_reg;
        phase_next     = phase_reg;
        high_next      = high_reg;
        bit_idx_next   = bit_idx_reg;
        shift_next     = shift_reg;
        byte_done      = 1'b0;
        start_err      = 1'b0;

        if (!kind)
        begin
            // edge check only starts a byte from idle with the line low
            if (!receiving_reg && !line_level)
            begin
                receiving_next = 1'b1;
                phase_next     = 2'd0;
                high_next      = 2'd0;
                bit_idx_next   = 4'd0;
                shift_next     = 8'd0;
            end
        end
        else if (receiving_reg)
        begin
            if (phase_reg == 2'd3)
            begin
                // idle tick between bits
                phase_next = 2'd0;
            end
            else if (phase_reg == 2'd2)
            begin
                // third sample: majority vote and shift in
                phase_next = 2'd3;
                high_next  = 2'd0;
                shift_next = {(high_inc > 2'd1), shift_reg[7:1]};
                if (bit_idx_reg == 4'd8)
                begin
                    receiving_next = 1'b0;
                    byte_done      = 1'b1;
                end
                else if (bit_idx_reg == 4'd0 && shift_next != 8'd0)
                begin
                    receiving_next = 1'b0;
                    start_err      = 1'b1;
                end
                else
                begin
                    bit_idx_next = bit_idx_reg + 4'd1;
                end
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
                high_next  = high_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            phase_reg     <= 2'd0;
            high_reg      <= 2'd0;
            bit_idx_reg   <= 4'd0;
            shift_reg     <= 8'd0;
        end
        else if (item_accept)
        begin
            receiving_reg <= receiving_next;
            phase_reg     <= phase_next;
            high_reg      <= high_next;
            bit_idx_reg   <= bit_idx_next;
            shift_reg     <= shift_next;
        end
    end

    // ---------------------------------------------------------------- frame parser
    irsbfd_frame_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .byte_strobe  (item_accept && byte_done),
        .rx_byte      (shift_next),
        .evt          (parse_evt),
        .value_first  (parse_v1),
        .value_second (parse_v2)
    );

    always_comb
    begin
        if (start_err)
        begin
            res_new.evt          = irsbfd_pkg::EV_START_ERR;
            res_new.byte_value   = 8'd0;
            res_new.value_first  = 16'd0;
            res_new.value_second = 16'd0;
        end
        else
        begin
            res_new.evt          = parse_evt;
            res_new.byte_value   = shift_next;
            res_new.value_first  = parse_v1;
            res_new.value_second = parse_v2;
        end
    end

    assign res_valid = byte_done || start_err;
    assign res_push  = item_accept && res_valid;

    // ---------------------------------------------------------------- result buffer
    assign out_free = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // skid entry drains first; no new transaction is accepted meanwhile
            out_valid_reg  <= skid_valid_reg || res_push;
            skid_valid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_new;
        end
        else if (res_push)
        begin
            skid_reg <= res_new;
        end
    end

    assign result_valid = out_valid_reg;
    assign event_res    = out_reg.evt;
    assign byte_value   = out_reg.byte_value;
    assign value_first  = out_reg.value_first;
    assign value_second = out_reg.value_second;

    // ---------------------------------------------------------------- assertions
    `IRSBFD_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry without output entry")
    `IRSBFD_ASSERT_IMP(a_result_on_tick, res_valid, kind && receiving_reg, "result outside a received tick")
    `IRSBFD_ASSERT_IMP(a_bit_index_range, receiving_reg, bit_idx_reg <= 4'd8, "bit index past the stop of a byte")
    `IRSBFD_ASSERT_NXT(a_stall_holds_result, out_valid_reg && result_stall, out_valid_reg, "stalled result dropped")

endmodule

[dv/ir_serial_byte_frame_decoder_unit_tb.sv]
// self-checking testbench of the ir serial byte frame decoder: random line traffic, apb codes
`timescale 1ns / 100ps

module ir_serial_byte_frame_decoder_unit_tb;

    // input transaction kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam int unsigned HOLD_CYCLES  = 800;
    localparam int unsigned DRAIN_LIMIT  = 3000;
    localparam int unsigned PRINT_LIMIT  = 100;
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;

    typedef enum int unsigned {STYLE_RANDOM, STYLE_ONES, STYLE_ZEROS, STYLE_POOL} code_style_t;

    typedef struct packed {
        logic is_tick;
        logic level;
    } line_item_t;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [irsbfd_pkg::ADDR_W-1:0]  paddr = '0;
    logic [irsbfd_pkg::DATA_W-1:0]  pwdata = '0;
    logic [irsbfd_pkg::DATA_W-1:0]  prdata;
    logic                           pready;
    logic                           item_valid = 1'b0;
    logic                           item_stall;
    logic                           kind = 1'b0;
    logic                           line_level = 1'b0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    logic [3:0]                     event_res;
    logic [7:0]                     byte_value;
    logic [15:0]                    value_first;
    logic [15:0]                    value_second;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    ir_serial_byte_frame_decoder_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .line_level   (line_level),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .event_res    (event_res),
        .byte_value   (byte_value),
        .value_first  (value_first),
        .value_second (value_second)
    );

    // ------------------------------------------------------------------
    // shared testbench state
    // ------------------------------------------------------------------
    line_item_t        line_events[$];     // input transactions still to be offered
    irsbfd_pkg::res_t  awaited_events[$];  // decoded events the block still owes us
    int unsigned error_count = 0;
    int unsigned items_queued = 0;
    int unsigned bytes_queued = 0;   // well-formed bytes and start errors queued

    // knobs set by the stimulus process, read by driver and monitor
    logic        send_calm = 1'b0;
    logic        recv_calm = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int unsigned hold_left = 0;

    // ------------------------------------------------------------------
    // decoder model: own copy of codes, receiver and frame parser state
    // ------------------------------------------------------------------
    irsbfd_pkg::cfg_t  code_regs = '0;
    logic        rx_busy = 1'b0;
    logic [1:0]  rx_phase = '0;
    logic [1:0]  rx_highs = '0;
    logic [3:0]  rx_bit = '0;
    logic [7:0]  rx_shift = '0;
    logic        hdr_pending = 1'b0;
    logic        mode_flow = 1'b0;
    logic        fl_on = 1'b0;
    logic [1:0]  fl_idx = '0;
    logic [15:0] fl_word1 = '0;
    logic [7:0]  fl_hi2 = '0;
    logic        id_on = 1'b0;
    logic [1:0]  id_idx = '0;
    logic [7:0]  id_b1 = '0;
    logic [7:0]  id_hi2 = '0;

    task automatic flag_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic digits_ok(input logic [7:0] b);
        return (b[3:0] <= 4'd9) && (b[7:4] <= 4'd9);
    endfunction

    // flow mode: start code, read flow, back, or four bcd bytes
    task automatic flow_byte(input logic [7:0] b, inout irsbfd_pkg::res_t r);
        if (!fl_on)
        begin
            fl_idx = '0;
            if (b == code_regs.flow_start_code)
                fl_on = 1'b1;
            else if (b == code_regs.read_flow_code)
                r.evt = irsbfd_pkg::EV_READ_FLOW;
            else if (b == code_regs.menu_codes[39:32])
                r.evt = irsbfd_pkg::EV_FLOW_BACK;
        end
        else if (!digits_ok(b))
        begin
            fl_on = 1'b0;
            fl_idx = '0;
            r.evt = irsbfd_pkg::EV_ABORT;
        end
        else
        begin
            case (fl_idx)
                2'd0:
                begin
                    fl_word1 = {b, 8'h00};
                    fl_idx = 2'd1;
                end
                2'd1:
                begin
                    fl_word1[7:0] = b;
                    fl_idx = 2'd2;
                end
                2'd2:
                begin
                    fl_hi2 = b;
                    fl_idx = 2'd3;
                end
                default:
                begin
                    fl_on = 1'b0;
                    fl_idx = '0;
                    r.evt = irsbfd_pkg::EV_FLOW;
                    r.value_first = fl_word1;
                    r.value_second = {fl_hi2, b};
                end
            endcase
        end
    endtask

    // ident mode: command codes in priority order, or three bcd bytes
    task automatic ident_byte(input logic [7:0] b, inout irsbfd_pkg::res_t r);
        if (!id_on)
        begin
            id_idx = '0;
            if (b == code_regs.ident_start_code)
                id_on = 1'b1;
            else if (b == code_regs.other_ident_codes[7:0])
                r.evt = irsbfd_pkg::EV_CLOSE;
            else if (b == code_regs.other_ident_codes[15:8])
                r.evt = irsbfd_pkg::EV_OPEN;
            else if (b == code_regs.menu_codes[7:0])
                r.evt = irsbfd_pkg::EV_ADD;
            else if (b == code_regs.menu_codes[15:8])
                r.evt = irsbfd_pkg::EV_SUB;
            else if (b == code_regs.menu_codes[23:16])
                r.evt = irsbfd_pkg::EV_CONFIRM;
            else if (b == code_regs.menu_codes[31:24])
                r.evt = irsbfd_pkg::EV_DOWN;
            else if (b == code_regs.menu_codes[39:32])
                r.evt = irsbfd_pkg::EV_BACK;
            else if (b == code_regs.other_ident_codes[23:16])
                r.evt = irsbfd_pkg::EV_READ_IDENT;
        end
        else if (!digits_ok(b))
        begin
            id_on = 1'b0;
            id_idx = '0;
            r.evt = irsbfd_pkg::EV_ABORT;
        end
        else
        begin
            case (id_idx)
                2'd0:
                begin
                    id_b1 = b;
                    id_idx = 2'd1;
                end
                2'd1:
                begin
                    id_hi2 = b;
                    id_idx = 2'd2;
                end
                // index three is unreachable and behaves as two
                default:
                begin
                    id_on = 1'b0;
                    id_idx = '0;
                    r.evt = irsbfd_pkg::EV_IDENT;
                    r.value_first = {8'h00, id_b1};
                    r.value_second = {id_hi2, b};
                end
            endcase
        end
    endtask

    // each byte needs a fresh header; the header selects the mode
    task automatic frame_byte(input logic [7:0] b, inout irsbfd_pkg::res_t r);
        if (!hdr_pending)
        begin
            if (b == irsbfd_pkg::HDR_IDENT)
            begin
                mode_flow = 1'b0;
                hdr_pending = 1'b1;
            end
            else if (b == irsbfd_pkg::HDR_FLOW)
            begin
                mode_flow = 1'b1;
                hdr_pending = 1'b1;
            end
        end
        else
        begin
            hdr_pending = 1'b0;
            if (mode_flow)
                flow_byte(b, r);
            else
                ident_byte(b, r);
        end
    endtask

    // one accepted input transaction: update the model, queue any event it causes
    task automatic decode_line_event(input logic is_tick, input logic level);
        irsbfd_pkg::res_t r;
        r = '0;
        if (is_tick == KIND_EDGE)
        begin
            // edge checks only matter when idle and with the line low
            if (!rx_busy && !level)
            begin
                rx_busy = 1'b1;
                rx_phase = '0;
                rx_highs = '0;
                rx_bit = '0;
                rx_shift = '0;
            end
        end
        else if (rx_busy)
        begin
            if (rx_phase == 2'd3)
                rx_phase = '0;  // idle tick after the third sample
            else
            begin
                if (level)
                    rx_highs = rx_highs + 2'd1;
                rx_phase = rx_phase + 2'd1;
                if (rx_phase == 2'd3)
                begin
                    rx_shift = {rx_highs > 2'd1, rx_shift[7:1]};
                    rx_highs = '0;
                    if (rx_bit == 4'd8)
                    begin
                        rx_busy = 1'b0;
                        r.byte_value = rx_shift;
                        frame_byte(rx_shift, r);
                        awaited_events.push_back(r);
                    end
                    else if (rx_bit == 4'd0 && rx_shift != 8'h00)
                    begin
                        rx_busy = 1'b0;
                        r.evt = irsbfd_pkg::EV_START_ERR;
                        awaited_events.push_back(r);
                    end
                    else
                        rx_bit = rx_bit + 4'd1;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // idle lengths: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // input driver: offers queued transactions, predicts on acceptance
    // ------------------------------------------------------------------
    int unsigned send_wait = 0;
    line_item_t  next_item;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                decode_line_event(kind, line_level);
            // payload and valid are only free to move once the transaction is gone
            if (!item_valid || !item_stall)
            begin
                if (send_wait != 0)
                begin
                    send_wait = send_wait - 1;
                    item_valid <= 1'b0;
                end
                else if (line_events.size() != 0)
                begin
                    next_item = line_events.pop_front();
                    item_valid <= 1'b1;
                    kind <= next_item.is_tick;
                    line_level <= next_item.level;
                    send_wait = send_calm ? 0 : pick_gap();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // long receiver hold-off, counted here so the sender keeps going
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // result monitor: checks each accepted transaction, drives stall
    // ------------------------------------------------------------------
    int unsigned       recv_wait = 0;
    logic              stall_now;
    irsbfd_pkg::res_t  want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_events.size() == 0)
                    flag_error($sformatf("unexpected result event %0d byte %02h",
                                         event_res, byte_value));
                else
                begin
                    want = awaited_events.pop_front();
                    if (event_res !== want.evt)
                        flag_error($sformatf("event_res %0d, expected %0d",
                                             event_res, want.evt));
                    if (byte_value !== want.byte_value)
                        flag_error($sformatf("byte_value %02h, expected %02h",
                                             byte_value, want.byte_value));
                    if (value_first !== want.value_first)
                        flag_error($sformatf("value_first %04h, expected %04h",
                                             value_first, want.value_first));
                    if (value_second !== want.value_second)
                        flag_error($sformatf("value_second %04h, expected %04h",
                                             value_second, want.value_second));
                end
            end
            if (hold_left != 0)
                stall_now = 1'b1;
            else if (recv_wait != 0)
            begin
                recv_wait = recv_wait - 1;
                stall_now = 1'b1;
            end
            else if (!recv_calm && $urandom_range(0, 9) == 0)
            begin
                recv_wait = pick_gap();
                stall_now = 1'b1;
            end
            else
                stall_now = 1'b0;
            result_stall <= stall_now;
        end
    end

    // ------------------------------------------------------------------
    // configuration access over apb
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input irsbfd_pkg::reg_idx_t idx,
                              input logic [63:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= irsbfd_pkg::ADDR_W'({idx, 3'b000});
        pwdata <= wr ? data : '0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (!wr && prdata !== irsbfd_pkg::DATA_W'(data))
            flag_error($sformatf("register %0d reads %h, expected %h", idx, prdata, data));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [63:0] reg_image(input irsbfd_pkg::cfg_t c,
                                              input irsbfd_pkg::reg_idx_t idx);
        case (idx)
            irsbfd_pkg::REG_IDENT_START: return 64'(c.ident_start_code);
            irsbfd_pkg::REG_FLOW_START:  return 64'(c.flow_start_code);
            irsbfd_pkg::REG_READ_FLOW:   return 64'(c.read_flow_code);
            irsbfd_pkg::REG_MENU:        return 64'(c.menu_codes);
            default:                     return 64'(c.other_ident_codes);
        endcase
    endfunction

    // write every register, then read each one back
    task automatic program_codes(input irsbfd_pkg::cfg_t c);
        for (int i = irsbfd_pkg::REG_IDENT_START; i <= irsbfd_pkg::REG_OTHER_IDENT; i++)
            apb_access(1'b1, irsbfd_pkg::reg_idx_t'(i),
                       reg_image(c, irsbfd_pkg::reg_idx_t'(i)));
        code_regs = c;
        for (int i = irsbfd_pkg::REG_IDENT_START; i <= irsbfd_pkg::REG_OTHER_IDENT; i++)
            apb_access(1'b0, irsbfd_pkg::reg_idx_t'(i),
                       reg_image(c, irsbfd_pkg::reg_idx_t'(i)));
    endtask

    // pool style draws every code from three values so that codes collide
    function automatic irsbfd_pkg::cfg_t make_codes(input code_style_t style);
        logic [7:0]  pool [3];
        logic [87:0] raw;
        for (int i = 0; i < 3; i++)
            pool[i] = 8'($urandom);
        for (int i = 0; i < 11; i++)
        begin
            case (style)
                STYLE_ONES:  raw[8*i +: 8] = 8'hff;
                STYLE_ZEROS: raw[8*i +: 8] = 8'h00;
                STYLE_POOL:  raw[8*i +: 8] = pool[$urandom_range(0, 2)];
                default:     raw[8*i +: 8] = 8'($urandom);
            endcase
        end
        return irsbfd_pkg::cfg_t'(raw);
    endfunction

    // ------------------------------------------------------------------
    // stimulus building: line transactions, bits, bytes and frames
    // ------------------------------------------------------------------
    task automatic push_item(input logic is_tick, input logic level);
        line_item_t it;
        it.is_tick = is_tick;
        it.level = level;
        line_events.push_back(it);
        items_queued++;
    endtask

    // three samples with the wanted majority, an ignored edge now and then, the idle tick
    task automatic push_bit(input logic v);
        logic [2:0] s;
        s = {3{v}};
        if ($urandom_range(0, 3) == 0)
            s[$urandom_range(0, 2)] = ~v;
        push_item(KIND_TICK, s[0]);
        // still receiving here, so any edge check is ignored
        if ($urandom_range(0, 15) == 0)
            push_item(KIND_EDGE, 1'($urandom_range(0, 1)));
        push_item(KIND_TICK, s[1]);
        push_item(KIND_TICK, s[2]);
        push_item(KIND_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic push_byte(input logic [7:0] b);
        // stray line activity while idle
        if ($urandom_range(0, 9) == 0)
        begin
            push_item(KIND_TICK, 1'($urandom_range(0, 1)));
            push_item(KIND_EDGE, 1'b1);
        end
        push_item(KIND_EDGE, 1'b0);
        push_bit(1'b0);
        for (int i = 0; i < 8; i++)
            push_bit(b[i]);
        bytes_queued++;
    endtask

    task automatic push_start_error();
        push_item(KIND_EDGE, 1'b0);
        push_bit(1'b1);
        bytes_queued++;
    endtask

    // broken traffic, then enough ticks to finish any byte it started
    task automatic push_noise();
        int unsigned n;
        n = $urandom_range(1, 30);
        push_item(KIND_EDGE, 1'b0);
        repeat (n)
            push_item(1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)));
        repeat (36)
            push_item(KIND_TICK, 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [7:0] mode_code(input logic flow);
        logic [71:0] ident_set;
        logic [23:0] flow_set;
        int unsigned k;
        ident_set = {code_regs.menu_codes, code_regs.other_ident_codes,
                     code_regs.ident_start_code};
        flow_set = {code_regs.menu_codes[39:32], code_regs.read_flow_code,
                    code_regs.flow_start_code};
        if (flow)
        begin
            k = $urandom_range(0, 2);
            return flow_set[8*k +: 8];
        end
        k = $urandom_range(0, 8);
        return ident_set[8*k +: 8];
    endfunction

    function automatic logic [7:0] bcd_pair();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    function automatic logic [7:0] bad_pair();
        logic [7:0] b;
        b = bcd_pair();
        case ($urandom_range(0, 2))
            0: b[3:0] = 4'($urandom_range(10, 15));
            1: b[7:4] = 4'($urandom_range(10, 15));
            default: b = {4'($urandom_range(10, 15)), 4'($urandom_range(10, 15))};
        endcase
        return b;
    endfunction

    // one frame: mostly well-formed commands and payloads, some noise
    task automatic gen_frame();
        int unsigned pick;
        int unsigned n;
        int unsigned bad_at;
        logic        flow;
        logic [7:0]  hdr;
        logic [7:0]  other_hdr;
        pick = $urandom_range(0, 99);
        flow = 1'($urandom_range(0, 1));
        hdr = flow ? irsbfd_pkg::HDR_FLOW : irsbfd_pkg::HDR_IDENT;
        other_hdr = flow ? irsbfd_pkg::HDR_IDENT : irsbfd_pkg::HDR_FLOW;
        if (pick < 35)
        begin
            // header and command code
            push_byte(hdr);
            push_byte(($urandom_range(0, 3) != 0) ? mode_code(flow) : 8'($urandom));
        end
        else if (pick < 65)
        begin
            // bcd payload, sometimes aborted by a bad digit
            n = flow ? 4 : 3;
            bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : n;
            push_byte(hdr);
            push_byte(flow ? code_regs.flow_start_code : code_regs.ident_start_code);
            for (int i = 0; i < n; i++)
            begin
                // the other mode may step in between payload bytes
                if ($urandom_range(0, 14) == 0)
                begin
                    push_byte(other_hdr);
                    push_byte(mode_code(~flow));
                end
                push_byte(hdr);
                if (i == bad_at)
                begin
                    push_byte(bad_pair());
                    break;
                end
                push_byte(bcd_pair());
            end
        end
        else if (pick < 78)
        begin
            // lone byte, extremes included
            case ($urandom_range(0, 3))
                0: push_byte(8'h00);
                1: push_byte(8'hff);
                default: push_byte(8'($urandom));
            endcase
        end
        else if (pick < 86)
        begin
            // header followed by another header byte
            push_byte(hdr);
            push_byte($urandom_range(0, 1) ? irsbfd_pkg::HDR_FLOW : irsbfd_pkg::HDR_IDENT);
        end
        else if (pick < 94)
            push_start_error();
        else
            push_noise();
    endtask

    // sender drained, then every awaited event in, then the result latency
    task automatic wait_idle();
        int unsigned waited;
        do
            @(negedge clk);
        while (line_events.size() != 0 || item_valid);
        waited = 0;
        while (awaited_events.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (awaited_events.size() != 0)
        begin
            flag_error($sformatf("%0d expected results never arrived",
                                 awaited_events.size()));
            awaited_events.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        code_style_t style;
        int unsigned items_mark;
        int unsigned bytes_mark;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored ticks and edges, edges while receiving, start errors
        push_item(KIND_TICK, 1'b0);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_EDGE, 1'b1);
        push_item(KIND_EDGE, 1'b0);
        push_item(KIND_EDGE, 1'b0);
        push_item(KIND_EDGE, 1'b1);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_TICK, 1'b0);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_EDGE, 1'b0);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_EDGE, 1'b0);
        push_item(KIND_TICK, 1'b0);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_TICK, 1'b1);
        wait_idle();

        // phases: typical codes, all ones, all zeros, colliding codes, typical again
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1: style = STYLE_ONES;
                2: style = STYLE_ZEROS;
                3: style = STYLE_POOL;
                default: style = STYLE_RANDOM;
            endcase
            program_codes(make_codes(style));
            send_calm <= (phase == 1 || phase == 3);
            recv_calm <= (phase == 1);
            // receiver holds off while the sender streams, filling the block
            if (phase == 3)
                hold_req <= ~hold_req;
            items_mark = items_queued;
            bytes_mark = bytes_queued;
            while (items_queued - items_mark < 200 || bytes_queued - bytes_mark < 4)
                gen_frame();
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
